/* sv/eight_way_writeback_data_cache_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the write-back data cache core
// Active in simulation, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef EIGHT_WAY_WRITEBACK_DATA_CACHE_CORE_ASSERT_SVH
`define EIGHT_WAY_WRITEBACK_DATA_CACHE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define EWDC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EWDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EWDC_ASSERT(lbl, clk, rst, prop, msg)
`define EWDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/ewdc_pkg.sv */
// ----------------------------------------------------------------------------
// ewdc_pkg
// Shared codes, default geometry and the queued word type.
// ----------------------------------------------------------------------------
package ewdc_pkg;

  localparam int SET_COUNT_DEF  = 256;
  localparam int WAY_COUNT_DEF  = 8;
  localparam int LINE_WORDS_DEF = 8;

  localparam int         AGE_W   = 3;
  localparam logic [2:0] AGE_MAX = 3'd7;

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_REFILL = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [2:0] ST_HIT    = 3'd0;
  localparam logic [2:0] ST_WB     = 3'd1;
  localparam logic [2:0] ST_FETCH  = 3'd2;
  localparam logic [2:0] ST_TAKEN  = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;
  localparam logic [2:0] ST_STRAY  = 3'd5;
  localparam logic [2:0] ST_BUSY   = 3'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] address;
    logic [31:0] data_word;
  } item_t;

endpackage

/* sv/eight_way_writeback_data_cache_core.sv */
// ----------------------------------------------------------------------------
// eight_way_writeback_data_cache_core
// Set-associative write-back, write-allocate data cache with age-based
// replacement.
//
// Input channel (in_valid/in_ready): one word carries command, address and
// data_word. Reads and writes access the cache; refill words deliver the
// fetched line, one word per item, in word order. Command three is dropped.
// Output channel (out_valid/out_ready): status, word_out, mem_address, last.
// A hit gives one result; a miss gives LINE_WORDS writeback words when the
// victim is dirty, then a fetch request; only the fetch request is marked last.
// A hit and a clean miss's fetch request pass the queue, the lookup
// state and the result register; a miss done passes the finish state in
// place of the lookup; refill taken, busy and stray go from idle straight
// to the result register. Each writeback word waits on the data RAM's
// registered read port. The engine takes a new word only when idle. The
// two-entry queue keeps the input open while a result waits, so a stalled
// receiver only holds the engine; the input fills after two queued words.
// Reset: a clearing pass walks the tag RAM one set per cycle, through all
// SET_COUNT sets (256 by default), with in_ready low throughout.
// ----------------------------------------------------------------------------
module eight_way_writeback_data_cache_core import ewdc_pkg::*; #(
  parameter int SET_COUNT  = SET_COUNT_DEF,
  parameter int WAY_COUNT  = WAY_COUNT_DEF,
  parameter int LINE_WORDS = LINE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] address,
  input  logic [31:0] data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] word_out,
  output logic [31:0] mem_address,
  output logic        last
);

  // front to back queue
  logic  q_valid;
  logic  q_ready;
  item_t q_item;
  logic  hold;

  ewdc_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .address(address), .data_word(data_word),
    .hold(hold),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  // engine with tag and data RAMs and the result register
  ewdc_back #(
    .SET_COUNT(SET_COUNT), .WAY_COUNT(WAY_COUNT), .LINE_WORDS(LINE_WORDS)
  ) u_back (
    .clk(clk), .rst(rst), .hold(hold),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .word_out(word_out), .mem_address(mem_address),
    .last(last)
  );

endmodule

/* sv/ewdc_ram.sv */
// ----------------------------------------------------------------------------
// ewdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ewdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/ewdc_front.sv */
// ----------------------------------------------------------------------------
// ewdc_front
// Input side: takes words, drops command three, two-entry queue to the back.
// ----------------------------------------------------------------------------
module ewdc_front import ewdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] address,
  input  logic [31:0] data_word,
  input  logic        hold,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign in_ready = (count != 2'd2) && !hold;
  // command three never enters the queue: it has no result
  assign push     = in_valid && in_ready && (command != CMD_NONE);
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{command: command, address: address, data_word: data_word};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* sv/ewdc_back.sv */
// ----------------------------------------------------------------------------
// ewdc_back
// Cache engine: tag row lookup, hit service, victim choice, writeback,
// refill and result register.
// ----------------------------------------------------------------------------
`include "eight_way_writeback_data_cache_core_assert.svh"

module ewdc_back import ewdc_pkg::*; #(
  parameter int SET_COUNT  = SET_COUNT_DEF,
  parameter int WAY_COUNT  = WAY_COUNT_DEF,
  parameter int LINE_WORDS = LINE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  output logic        hold,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] word_out,
  output logic [31:0] mem_address,
  output logic        last
);

  localparam int SW     = $clog2(SET_COUNT);
  localparam int WW     = $clog2(WAY_COUNT);
  localparam int LW     = $clog2(LINE_WORDS);
  localparam int TW     = 32 - 2 - LW - SW;
  localparam int DEPTH  = SET_COUNT * WAY_COUNT * LINE_WORDS;
  localparam int ROW_W  = WAY_COUNT * (2 + AGE_W + TW);
  localparam logic [LW-1:0] LAST_WORD = LW'(LINE_WORDS - 1);
  localparam logic [SW-1:0] LAST_SET  = SW'(SET_COUNT - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_WBRD  = 4'd3;
  localparam logic [3:0] S_WBEM  = 4'd4;
  localparam logic [3:0] S_FETCH = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_RDEM  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  typedef struct packed {
    logic [WAY_COUNT-1:0]            valid;
    logic [WAY_COUNT-1:0]            dirty;
    logic [WAY_COUNT-1:0][AGE_W-1:0] age;
    logic [WAY_COUNT-1:0][TW-1:0]    tag;
  } row_t;

  logic [3:0]    state;
  logic [SW-1:0] clr_set;

  logic          cur_write;
  logic [31:0]   cur_addr;
  logic [31:0]   cur_data;
  logic          pending;
  logic          p_write;
  logic [31:0]   p_addr;
  logic [31:0]   p_data;
  logic [WW-1:0] p_way;
  logic [LW-1:0] rcnt;
  logic [LW-1:0] k;
  logic [TW-1:0] wb_tag;
  logic [2:0]    res_status;

  logic [SW-1:0] q_set, cur_set, p_set;
  logic [TW-1:0] cur_tag, p_tag;
  logic [LW-1:0] cur_word, p_word;

  assign q_set    = q_item.address[LW+2 +: SW];
  assign cur_set  = cur_addr[LW+2 +: SW];
  assign cur_tag  = cur_addr[31 -: TW];
  assign cur_word = cur_addr[2 +: LW];
  assign p_set    = p_addr[LW+2 +: SW];
  assign p_tag    = p_addr[31 -: TW];
  assign p_word   = p_addr[2 +: LW];

  logic                    m_we, m_re;
  logic [SW-1:0]           m_waddr, m_raddr;
  logic [ROW_W-1:0]        m_wdata, m_rdata;
  logic                    d_we, d_re;
  logic [SW+WW+LW-1:0]     d_waddr, d_raddr;
  logic [31:0]             d_wdata, d_rdata;

  ewdc_ram #(.WIDTH(ROW_W), .DEPTH(SET_COUNT)) u_meta (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .re(m_re), .raddr(m_raddr), .rdata(m_rdata)
  );

  ewdc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_data (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
  );

  // row decode: hit, victim, updated rows
  row_t          rd_row, miss_row, hitw_row, fin_row;
  logic          hit, inv_found;
  logic [WW-1:0] hit_way, inv_way, age_way, victim;
  logic [AGE_W-1:0] best;

  assign rd_row = row_t'(m_rdata);

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    for (int i = WAY_COUNT - 1; i >= 0; i--) begin
      if (rd_row.valid[i] && rd_row.tag[i] == cur_tag) begin
        hit     = 1'b1;
        hit_way = WW'(i);
      end
      if (!rd_row.valid[i]) begin
        inv_found = 1'b1;
        inv_way   = WW'(i);
      end
    end
    best    = rd_row.age[0];
    age_way = '0;
    for (int i = 1; i < WAY_COUNT; i++) begin
      if (rd_row.age[i] >= best) begin
        best    = rd_row.age[i];
        age_way = WW'(i);
      end
    end
    victim = inv_found ? inv_way : age_way;

    miss_row = rd_row;
    for (int i = 0; i < WAY_COUNT; i++) begin
      if (WW'(i) == victim) begin
        miss_row.valid[i] = 1'b0;
        miss_row.dirty[i] = 1'b0;
        miss_row.age[i]   = '0;
      end else if (rd_row.age[i] != AGE_MAX) begin
        miss_row.age[i] = rd_row.age[i] + 1'b1;
      end
    end

    hitw_row = rd_row;
    hitw_row.dirty[hit_way] = 1'b1;

    fin_row = rd_row;
    fin_row.valid[p_way] = 1'b1;
    fin_row.dirty[p_way] = p_write;
    fin_row.age[p_way]   = '0;
    fin_row.tag[p_way]   = p_tag;
  end

  logic out_free;
  logic emit_now;
  assign out_free = !out_valid || out_ready;
  assign emit_now = out_free && (state inside {S_WBEM, S_FETCH, S_RDEM, S_EMIT});
  assign hold     = (state == S_CLEAR);

  always_comb begin
    m_we    = 1'b0;
    m_waddr = cur_set;
    m_wdata = miss_row;
    m_re    = 1'b0;
    m_raddr = q_set;
    d_we    = 1'b0;
    d_waddr = {p_set, p_way, rcnt};
    d_wdata = q_item.data_word;
    d_re    = 1'b0;
    d_raddr = {cur_set, hit_way, cur_word};
    q_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_set;
        m_wdata = '0;
      end
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_item.command == CMD_REFILL && pending) begin
            d_we = 1'b1;
            if (rcnt == LAST_WORD) begin
              m_re    = 1'b1;
              m_raddr = p_set;
            end
          end else if (q_item.command != CMD_REFILL && !pending) begin
            m_re = 1'b1;
          end
        end
      end
      S_LOOK: begin
        if (hit) begin
          if (cur_write) begin
            d_we    = 1'b1;
            d_waddr = {cur_set, hit_way, cur_word};
            d_wdata = cur_data;
            m_we    = 1'b1;
            m_wdata = hitw_row;
          end else begin
            d_re = 1'b1;
          end
        end else begin
          m_we = 1'b1;
        end
      end
      S_WBRD: begin
        d_re    = 1'b1;
        d_raddr = {p_set, p_way, k};
      end
      S_FIN: begin
        m_we    = 1'b1;
        m_waddr = p_set;
        m_wdata = fin_row;
        if (p_write) begin
          d_we    = 1'b1;
          d_waddr = {p_set, p_way, p_word};
          d_wdata = p_data;
        end else begin
          d_re    = 1'b1;
          d_raddr = {p_set, p_way, p_word};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_set   <= '0;
      pending   <= 1'b0;
      rcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result loaded this cycle keeps valid high
      if (out_valid && out_ready && !emit_now) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_set <= clr_set + 1'b1;
          if (clr_set == LAST_SET) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            if (pending && q_item.command != CMD_REFILL) begin
              res_status <= ST_BUSY;
              state      <= S_EMIT;
            end else if (!pending && q_item.command == CMD_REFILL) begin
              res_status <= ST_STRAY;
              state      <= S_EMIT;
            end else if (pending) begin
              if (rcnt != LAST_WORD) begin
                rcnt       <= rcnt + 1'b1;
                res_status <= ST_TAKEN;
                state      <= S_EMIT;
              end else begin
                rcnt  <= '0;
                state <= S_FIN;
              end
            end else begin
              cur_write <= (q_item.command == CMD_WRITE);
              cur_addr  <= q_item.address;
              cur_data  <= q_item.data_word;
              state     <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          res_status <= ST_HIT;
          if (hit) begin
            state <= cur_write ? S_EMIT : S_RDEM;
          end else begin
            pending <= 1'b1;
            p_write <= cur_write;
            p_addr  <= cur_addr;
            p_data  <= cur_data;
            p_way   <= victim;
            k       <= '0;
            wb_tag  <= rd_row.tag[victim];
            if (rd_row.valid[victim] && rd_row.dirty[victim]) begin
              state <= S_WBRD;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_WBRD: state <= S_WBEM;
        S_WBEM: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= ST_WB;
            word_out    <= d_rdata;
            mem_address <= {wb_tag, p_set, k, 2'b00};
            last        <= 1'b0;
            k           <= k + 1'b1;
            state       <= (k == LAST_WORD) ? S_FETCH : S_WBRD;
          end
        end
        S_FETCH: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= ST_FETCH;
            word_out    <= '0;
            mem_address <= {p_addr[31:LW+2], (LW+2)'(0)};
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_FIN: begin
          pending    <= 1'b0;
          res_status <= ST_DONE;
          state      <= p_write ? S_EMIT : S_RDEM;
        end
        S_RDEM: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            word_out    <= d_rdata;
            mem_address <= '0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            word_out    <= '0;
            mem_address <= '0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `EWDC_ASSERT(a_rcnt_pending, clk, rst, (rcnt != '0) |-> pending, "refill count without miss")
  `EWDC_ASSERT(a_clear_quiet, clk, rst, (state == S_CLEAR) |-> !out_valid, "result during clear")
  `EWDC_ASSERT(a_wb_not_last, clk, rst, (out_valid && status == ST_WB) |-> !last, "writeback marked last")
  `EWDC_ASSERT_ALWAYS(a_reset_clear, clk, $past(rst) |-> (state == S_CLEAR), "no clear after reset")

endmodule

/* sim/ewdc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ewdc_checker
// Watches both channels of the cache core, keeps a shadow copy of the cache
// state, predicts every result word and compares it in order.
// ----------------------------------------------------------------------------
module ewdc_checker import ewdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] address,
  input  logic [31:0] data_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [31:0] word_out,
  input  logic [31:0] mem_address,
  input  logic        last,
  output int          fail_count,
  output int          pending_count
);

  localparam int SETS = SET_COUNT_DEF;
  localparam int WAYS = WAY_COUNT_DEF;
  localparam int LW   = LINE_WORDS_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] word;
    logic [31:0] maddr;
    logic        last;
  } result_t;

  logic            sh_valid [SETS*WAYS];
  logic            sh_dirty [SETS*WAYS];
  logic [2:0]      sh_age   [SETS*WAYS];
  logic [18:0]     sh_tag   [SETS*WAYS];
  logic [31:0]     sh_data  [SETS*WAYS*LW];
  logic            miss_open;
  logic            miss_is_write;
  logic [31:0]     miss_addr;
  logic [31:0]     miss_data;
  int              miss_way;
  int              fill_idx;
  result_t         expected_results [$];

  assign pending_count = expected_results.size();

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic push(input logic [2:0] s, input logic [31:0] w,
                      input logic [31:0] a);
    expected_results.push_back('{s, w, a, 1'b0});
  endtask

  // shadow of one accepted input word
  task automatic predict_cache(input logic [1:0] cmd, input logic [31:0] a,
                               input logic [31:0] d);
    int set, li, victim, best, wb;
    logic [18:0] tg;
    logic [2:0] wd;
    if (cmd == CMD_NONE) return;
    if (miss_open) begin
      if (cmd != CMD_REFILL) begin
        push(ST_BUSY, 0, 0);
      end else begin
        li = int'(miss_addr[12:5]) * WAYS + miss_way;
        wb = li * LW;
        sh_data[wb + fill_idx] = d;
        if (fill_idx < LW - 1) begin
          fill_idx++;
          push(ST_TAKEN, 0, 0);
        end else begin
          wd = miss_addr[4:2];
          sh_valid[li] = 1'b1;
          sh_tag[li] = miss_addr[31:13];
          sh_age[li] = 0;
          sh_dirty[li] = miss_is_write;
          if (miss_is_write) sh_data[wb + wd] = miss_data;
          push(ST_DONE, miss_is_write ? 32'd0 : sh_data[wb + wd], 0);
          miss_open = 1'b0;
          fill_idx = 0;
        end
      end
    end else if (cmd == CMD_REFILL) begin
      push(ST_STRAY, 0, 0);
    end else begin
      set = a[12:5];
      tg = a[31:13];
      wd = a[4:2];
      for (int w = 0; w < WAYS; w++) begin
        li = set * WAYS + w;
        if (sh_valid[li] && sh_tag[li] == tg) begin
          if (cmd == CMD_WRITE) begin
            sh_data[li*LW + wd] = d;
            sh_dirty[li] = 1'b1;
            push(ST_HIT, 0, 0);
          end else begin
            push(ST_HIT, sh_data[li*LW + wd], 0);
          end
          expected_results[$].last = 1'b1;
          return;
        end
      end
      victim = -1;
      for (int w = 0; w < WAYS; w++)
        if (victim < 0 && !sh_valid[set*WAYS + w]) victim = w;
      if (victim < 0) begin
        victim = 0;
        best = sh_age[set*WAYS];
        for (int w = 1; w < WAYS; w++)
          if (sh_age[set*WAYS + w] >= best) begin
            best = sh_age[set*WAYS + w];
            victim = w;
          end
      end
      for (int w = 0; w < WAYS; w++)
        if (w != victim && sh_age[set*WAYS + w] < AGE_MAX)
          sh_age[set*WAYS + w]++;
      li = set * WAYS + victim;
      sh_age[li] = 0;
      if (sh_valid[li] && sh_dirty[li])
        for (int k = 0; k < LW; k++)
          push(ST_WB, sh_data[li*LW + k],
               {sh_tag[li], set[7:0], k[2:0], 2'b00});
      sh_valid[li] = 1'b0;
      sh_dirty[li] = 1'b0;
      miss_open = 1'b1;
      miss_is_write = (cmd == CMD_WRITE);
      miss_addr = a;
      miss_data = d;
      miss_way = victim;
      fill_idx = 0;
      push(ST_FETCH, 0, {a[31:5], 5'd0});
    end
    expected_results[$].last = 1'b1;
  endtask

  initial begin
    fail_count = 0;
    miss_open = 0;
    fill_idx = 0;
    miss_way = 0;
    miss_is_write = 0;
    miss_addr = 0;
    miss_data = 0;
    for (int i = 0; i < SETS*WAYS; i++) begin
      sh_valid[i] = 0;
      sh_dirty[i] = 0;
      sh_age[i] = 0;
      sh_tag[i] = 0;
    end
    for (int i = 0; i < SETS*WAYS*LW; i++) sh_data[i] = 0;
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst) begin
      if (in_valid && in_ready) predict_cache(command, address, data_word);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected word status %0d", status));
        end else begin
          exp_r = expected_results.pop_front();
          if (status !== exp_r.status)
            report($sformatf("status %0d, want %0d", status, exp_r.status));
          if (word_out !== exp_r.word)
            report($sformatf("word_out %h, want %h", word_out, exp_r.word));
          if (mem_address !== exp_r.maddr)
            report($sformatf("mem_address %h, want %h", mem_address, exp_r.maddr));
          if (last !== exp_r.last)
            report($sformatf("last %b, want %b", last, exp_r.last));
        end
      end
    end
  end

endmodule

/* sim/tb_eight_way_writeback_data_cache_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_eight_way_writeback_data_cache_core
// Drives reads, writes and refill words into the cache core with random
// gaps and output stalls; a checker beside the core predicts every result.
// ----------------------------------------------------------------------------
module tb_eight_way_writeback_data_cache_core;
  import ewdc_pkg::*;

  localparam int IDLE_LIMIT = 4000;  // covers clearing pass and long stalls
  localparam int ITEM_TARGET = 130;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [31:0] address;
  logic [31:0] data_word;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [31:0] word_out;
  logic [31:0] mem_address;
  logic        last;
  int          fail_count;
  int          pending_count;
  int          quiet_cycles;
  logic        stim_done;
  logic [31:0] hot_addr [8];   // a few tags sharing one set to force eviction
  int          items_sent;
  int          acc_count;      // accepted words that owe results
  int          done_count;     // results marked last
  logic        last_fetch;     // final result seen was a fetch request

  eight_way_writeback_data_cache_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .address(address), .data_word(data_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .word_out(word_out), .mem_address(mem_address),
    .last(last)
  );

  ewdc_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .address(address), .data_word(data_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .word_out(word_out), .mem_address(mem_address),
    .last(last),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Send one word: random gap first, then hold valid until accepted.
  task automatic send_word(input logic [1:0] c, input logic [31:0] a,
                           input logic [31:0] d);
    int gap;
    items_sent++;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    address <= a;
    data_word <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  // Access followed by a full line refill with random memory words.
  task automatic access_with_fill(input logic [1:0] c, input logic [31:0] a,
                                  input logic [31:0] d);
    send_word(c, a, d);
    for (int k = 0; k < LINE_WORDS_DEF; k++)
      send_word(CMD_REFILL, $urandom, $urandom);
  endtask

  // Idle the input until every accepted word has its final result; report
  // whether that final result opened a miss.
  task automatic wait_verdict(output logic miss);
    in_valid <= 1'b0;
    @(posedge clk);
    while (done_count != acc_count) @(posedge clk);
    miss = last_fetch;
  endtask

  // Output side stalls: bursts of ready with random holds in between.
  initial begin
    int hold;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Counts words owed a result and final results returned.
  always @(posedge clk) begin
    if (rst) begin
      acc_count  <= 0;
      done_count <= 0;
      last_fetch <= 1'b0;
    end else begin
      if (in_valid && in_ready && command != CMD_NONE)
        acc_count <= acc_count + 1;
      if (out_valid && out_ready && last) begin
        done_count <= done_count + 1;
        last_fetch <= (status == ST_FETCH);
      end
    end
  end

  initial begin
    logic [31:0] a;
    int pick;
    logic miss;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_READ;
    address = 0;
    data_word = 0;
    stim_done = 1'b0;
    quiet_cycles = 0;
    items_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 8; i++)
      hot_addr[i] = {19'($urandom_range(0, 32'h7ffff)) | 19'(i << 16), 8'h5a, 5'd0};

    // Directed: stray refill, ignored command, read and write miss,
    // busy during a miss, hits at field extremes.
    send_word(CMD_REFILL, 32'hffffffff, 32'hffffffff);
    send_word(CMD_NONE, 32'h0, 32'h0);
    access_with_fill(CMD_READ, 32'h0, 32'h0);
    send_word(CMD_READ, 32'h0000001c, 0);
    access_with_fill(CMD_WRITE, 32'hffffffff, 32'hffffffff);
    send_word(CMD_WRITE, 32'h0000001c, 32'ha5a5a5a5);
    send_word(CMD_READ, 32'h00000004, 32'hffffffff);
    send_word(CMD_READ, 32'h12345678, 0);
    send_word(CMD_WRITE, 32'h0, 32'h1);
    send_word(CMD_NONE, 32'hffffffff, 32'hffffffff);
    for (int k = 0; k < LINE_WORDS_DEF; k++)
      send_word(CMD_REFILL, 32'h0, $urandom);
    send_word(CMD_READ, 32'hfffffffc, 0);

    // Random: mostly well-formed accesses on a crowded set so that dirty
    // victims and age ties occur, plus noise.
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) a = hot_addr[3'($urandom_range(0, 7))] | ($urandom & 32'h1c);
      else if (pick < 8) a = {19'($urandom_range(0, 32'h7ffff)), 8'h5a,
                              5'($urandom)};
      else a = $urandom;
      if (pick == 9 && $urandom_range(0, 1)) begin
        send_word(2'($urandom_range(2, 3)), $urandom, $urandom);
      end else begin
        send_word($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, a, $urandom);
        wait_verdict(miss);
        if (miss)
          for (int k = 0; k < LINE_WORDS_DEF; k++) begin
            if ($urandom_range(0, 15) == 0)
              send_word($urandom_range(0, 1) ? CMD_READ : CMD_WRITE,
                        $urandom, $urandom);
            send_word(CMD_REFILL, $urandom, $urandom);
          end
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done === 1'b1);
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
